[sv/hc3_pkg.sv]
// Shared types and constants for the 3x3 Hill cipher encryptor.
package hc3_pkg;

    // Alphabet and block geometry
    localparam int unsigned LETTER_W   = 5;
    localparam int unsigned KEY_ROW_W  = 3 * LETTER_W;
    localparam int unsigned BLOCK_LEN  = 3;
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned QUOT_W     = 7;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;

    // Reciprocal of 26 scaled by 2**16; exact quotient for sums up to 3*31*31
    localparam logic [11:0] RECIP       = 12'd2521;
    localparam int unsigned RECIP_SHIFT = 16;

    // Key row reset values
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_ZERO_RST = 15'd9859;
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_ONE_RST  = 15'd4394;
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_TWO_RST  = 15'd17972;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_KEY_ROW_ZERO = 2'd0,
        REG_KEY_ROW_ONE  = 2'd1,
        REG_KEY_ROW_TWO  = 2'd2
    } reg_index_t;

    // Input word
    typedef struct packed {
        logic [LETTER_W-1:0] plain_letter;
        logic                end_of_message;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                last_of_message;
    } out_word_t;

    // One full (possibly padded) plaintext block
    typedef struct packed {
        logic [LETTER_W-1:0] p2;
        logic [LETTER_W-1:0] p1;
        logic [LETTER_W-1:0] p0;
        logic                last;
    } block_t;

    // Key matrix, one row per field
    typedef struct packed {
        logic [KEY_ROW_W-1:0] row_two;
        logic [KEY_ROW_W-1:0] row_one;
        logic [KEY_ROW_W-1:0] row_zero;
    } key_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_stat_t;

endpackage

[sv/hc3_front.sv]
// Front part: gathers letters into blocks of three and pads a closing block.
module hc3_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  hc3_pkg::in_word_t word,
    output logic              push,
    output hc3_pkg::block_t   push_block
);

    logic [1:0]                     position_reg, position_next;
    logic [hc3_pkg::LETTER_W-1:0]   letters_reg [2];
    logic                           close_block;

    // Close the block on its third letter or on the end flag
    assign close_block = (position_reg == 2'd2) || word.end_of_message;
    assign push        = take && close_block;

    // Build the block, padding missing letters with x
    always_comb begin
        push_block      = '0;
        push_block.last = word.end_of_message;
        case (position_reg)
            2'd0: begin
                push_block.p0 = word.plain_letter;
                push_block.p1 = hc3_pkg::PAD_LETTER;
                push_block.p2 = hc3_pkg::PAD_LETTER;
            end
            2'd1: begin
                push_block.p0 = letters_reg[0];
                push_block.p1 = word.plain_letter;
                push_block.p2 = hc3_pkg::PAD_LETTER;
            end
            default: begin
                push_block.p0 = letters_reg[0];
                push_block.p1 = letters_reg[1];
                push_block.p2 = word.plain_letter;
            end
        endcase
    end

    // Advance or restart the position count
    always_comb begin
        position_next = position_reg;
        if (take) begin
            if (close_block) begin
                position_next = 2'd0;
            end else begin
                position_next = position_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= 2'd0;
        end else begin
            position_reg <= position_next;
        end
    end

    // Hold buffered letters
    always_ff @(posedge aclk) begin
        if (take && !close_block) begin
            letters_reg[position_reg[0]] <= word.plain_letter;
        end
    end

    a_position_range: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg != 2'd3)
        else $error("block position out of range");

    a_push_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> position_reg == 2'd0)
        else $error("position not cleared after closing a block");

endmodule

[sv/hc3_queue.sv]
// Two-entry block queue between the front and back parts.
module hc3_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hc3_pkg::block_t      push_block,
    input  logic                 pop,
    output hc3_pkg::queue_stat_t stat,
    output hc3_pkg::block_t      head_block
);

    hc3_pkg::block_t entries_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign stat.full       = (count_reg == 2'd2);
    assign stat.head_valid = (count_reg != 2'd0);
    assign head_block      = entries_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed block
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_block;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.head_valid |-> !pop)
        else $error("pop from an empty queue");

endmodule

[sv/hc3_back.sv]
// Back part: one key row product per cycle unless stalled, reduced modulo 26, into the output register.
module hc3_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hc3_pkg::key_t        key,
    input  logic                 head_valid,
    input  hc3_pkg::block_t      head_block,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hc3_pkg::out_word_t   out_word
);

    localparam int unsigned LW = hc3_pkg::LETTER_W;
    localparam int unsigned SW = hc3_pkg::SUM_W;
    localparam int unsigned QW = hc3_pkg::QUOT_W;

    logic [1:0]               row_sel_reg, row_sel_next;
    logic [hc3_pkg::KEY_ROW_W-1:0] row;

    logic                     a_valid_reg, a_valid_next;
    logic [SW-1:0]            a_sum_reg;
    logic                     a_last_reg;
    logic                     b_valid_reg, b_valid_next;
    logic [SW-1:0]            b_sum_reg;
    logic [QW-1:0]            b_quot_reg;
    logic                     b_last_reg;
    logic                     c_valid_reg, c_valid_next;
    hc3_pkg::out_word_t       c_word_reg;

    logic                     a_ready, b_ready, c_ready;
    logic                     a_take, b_take, c_take;
    logic [2*LW-1:0]          prod0, prod1, prod2;
    logic [SW-1:0]            sum;
    logic [SW+SW-1:0]         recip_prod;
    logic [SW-1:0]            quot_x26;
    logic [SW-1:0]            residue;

    // Stage handshakes
    assign c_ready = !c_valid_reg || out_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign a_take  = head_valid && a_ready;
    assign b_take  = a_valid_reg && b_ready;
    assign c_take  = b_valid_reg && c_ready;
    assign pop     = a_take && (row_sel_reg == 2'd2);

    // Select key row
    always_comb begin
        case (row_sel_reg)
            2'd0:    row = key.row_zero;
            2'd1:    row = key.row_one;
            default: row = key.row_two;
        endcase
    end

    // Row product
    assign prod0 = row[0*LW +: LW] * head_block.p0;
    assign prod1 = row[1*LW +: LW] * head_block.p1;
    assign prod2 = row[2*LW +: LW] * head_block.p2;
    assign sum   = SW'(prod0) + SW'(prod1) + SW'(prod2);

    // Quotient by reciprocal, then residue
    assign recip_prod = a_sum_reg * hc3_pkg::RECIP;
    assign quot_x26   = SW'(b_quot_reg) * SW'(hc3_pkg::MODULUS);
    assign residue    = b_sum_reg - quot_x26;

    // Advance row counter and stage valids
    always_comb begin
        row_sel_next = row_sel_reg;
        if (a_take) begin
            row_sel_next = (row_sel_reg == 2'd2) ? 2'd0 : row_sel_reg + 2'd1;
        end
        a_valid_next = a_take || (a_valid_reg && !b_take);
        b_valid_next = b_take || (b_valid_reg && !c_take);
        c_valid_next = c_take || (c_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sel_reg <= 2'd0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            row_sel_reg <= row_sel_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Load stage payloads
    always_ff @(posedge aclk) begin
        if (a_take) begin
            a_sum_reg  <= sum;
            a_last_reg <= head_block.last && (row_sel_reg == 2'd2);
        end
        if (b_take) begin
            b_sum_reg  <= a_sum_reg;
            b_quot_reg <= recip_prod[hc3_pkg::RECIP_SHIFT +: QW];
            b_last_reg <= a_last_reg;
        end
        if (c_take) begin
            c_word_reg.cipher_letter   <= residue[LW-1:0];
            c_word_reg.last_of_message <= b_last_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_word  = c_word_reg;

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_sel_reg != 2'd3)
        else $error("row select out of range");

    a_letter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (c_word_reg.cipher_letter < hc3_pkg::MODULUS))
        else $error("cipher letter not reduced");

endmodule

[sv/hill_cipher_3x3_encrypt.sv]
// Top level of the 3x3 Hill cipher encryptor with its key registers.
//
//  Channel   Direction  Handshake            Word
//  s_        in         s_valid / s_ready    plaintext letter, end flag
//  m_        out        m_valid / m_ready    cipher letter, last flag
//  APB       in/out     psel, penable        key rows at 0x0, 0x4, 0x8
//
// Takes one letter per cycle while the two-block queue has room; emits one
// cipher letter per cycle while m_ready holds, from the three-stage row unit (sum,
// quotient, residue); m_valid rises after a closing block passes the queue and stages.
// An end flag on the first or second letter of a block gives three results for
// one or two letters, so the input stalls while the row unit drains the queue.
// Reset loads the default key, empties the queue and clears the block position.
module hill_cipher_3x3_encrypt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hc3_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output hc3_pkg::out_word_t m_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    hc3_pkg::key_t        key_reg;
    hc3_pkg::queue_stat_t q_stat;
    hc3_pkg::block_t      push_block;
    hc3_pkg::block_t      head_block;
    logic                 push, pop, s_take, cfg_write;
    hc3_pkg::reg_index_t  reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = hc3_pkg::reg_index_t'(paddr[3:2]);

    // Write key rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg.row_zero <= hc3_pkg::KEY_ROW_ZERO_RST;
            key_reg.row_one  <= hc3_pkg::KEY_ROW_ONE_RST;
            key_reg.row_two  <= hc3_pkg::KEY_ROW_TWO_RST;
        end else if (cfg_write) begin
            unique case (reg_index)
                hc3_pkg::REG_KEY_ROW_ZERO: key_reg.row_zero <= pwdata[14:0];
                hc3_pkg::REG_KEY_ROW_ONE:  key_reg.row_one  <= pwdata[14:0];
                hc3_pkg::REG_KEY_ROW_TWO:  key_reg.row_two  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read key rows
    always_comb begin
        unique case (reg_index)
            hc3_pkg::REG_KEY_ROW_ZERO: prdata = {17'd0, key_reg.row_zero};
            hc3_pkg::REG_KEY_ROW_ONE:  prdata = {17'd0, key_reg.row_one};
            hc3_pkg::REG_KEY_ROW_TWO:  prdata = {17'd0, key_reg.row_two};
            default:                   prdata = 32'd0;
        endcase
    end

    assign s_ready = !q_stat.full;
    assign s_take  = s_valid && s_ready;

    hc3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (s_take),
        .word       (s_word),
        .push       (push),
        .push_block (push_block)
    );

    hc3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_block (push_block),
        .pop        (pop),
        .stat       (q_stat),
        .head_block (head_block)
    );

    hc3_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key        (key_reg),
        .head_valid (q_stat.head_valid),
        .head_block (head_block),
        .pop        (pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_word   (m_word)
    );

endmodule
